FILE: sv/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

	// bitmap geometry
	localparam int MAX_BLOCKS = 4096;
	localparam int WORD_W     = 32;
	localparam int MAP_WORDS  = MAX_BLOCKS / WORD_W;
	localparam int WADDR_W    = $clog2(MAP_WORDS);
	localparam int OFF_W      = $clog2(WORD_W);

	// field widths
	localparam int BLK_W  = 12;
	localparam int CNT_W  = 13;
	localparam int KIND_W = 2;
	localparam int CIDX_W = 1;

	localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_TOTAL    = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_RESERVED = 1'b1;

	// reset values of the registers
	localparam logic [CNT_W-1:0] TOTAL_RST    = CNT_W'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] RESERVED_RST = CNT_W'(1);

	// bitmap memory access
	typedef struct packed {
		logic               clr;
		logic               rd_en;
		logic               wr_en;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  wdata;
	} map_req_t;

	// finished result
	typedef struct packed {
		logic             status;
		logic [BLK_W-1:0] block;
		logic [CNT_W-1:0] count;
	} rsp_t;

endpackage

FILE: sv/bba_map.sv
`timescale 1ns / 1ps

module bba_map
	import bba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  map_req_t          req,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0]    mem_q [MAP_WORDS];
	logic [MAP_WORDS-1:0] vld_q;
	logic [WORD_W-1:0]    rdata_q;
	logic                 rvld_q;

	// bitmap words, registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.addr];
		end
	end

	// one valid bit per word; a word never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end
			if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvld_q <= vld_q[req.addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

FILE: sv/bba_scan.sv
`timescale 1ns / 1ps

module bba_scan
	import bba_pkg::*;
(
	input  logic [WORD_W-1:0] word,
	input  logic              first,
	input  logic [OFF_W-1:0]  off,
	output logic              found,
	output logic [OFF_W-1:0]  pos
);

	logic [WORD_W-1:0] masked;

	// bits below the hint in the first word count as used
	always_comb begin
		masked = word;
		if (first) begin
			masked = word | ~(ALL_ONES << off);
		end
	end

	// lowest clear bit
	always_comb begin
		pos = '0;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (!masked[k]) begin
				pos = OFF_W'(k);
			end
		end
	end

	assign found = ~&masked;

endmodule

FILE: sv/bba_ctrl.sv
`timescale 1ns / 1ps

module bba_ctrl
	import bba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CNT_W-1:0]  total,
	input  logic [CNT_W-1:0]  reserved,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [KIND_W-1:0] req_kind,
	input  logic [BLK_W-1:0]  req_block,
	output logic              rsp_valid,
	input  logic              rsp_take,
	output rsp_t              rsp,
	output map_req_t          map_req,
	input  logic [WORD_W-1:0] map_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_WB,
		S_FILL,
		S_RESP
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   free_q;
	logic [BLK_W-1:0]   hint_q;
	logic [WADDR_W-1:0] word_q;
	logic               first_q;
	logic [OFF_W-1:0]   off_q;
	logic [CNT_W-1:0]   fill_q;
	logic [BLK_W-1:0]   bn_q;
	logic               status_q;
	logic [BLK_W-1:0]   block_q;

	logic [CNT_W-1:0]   tot;
	logic [CNT_W-1:0]   res_eff;
	logic               alloc_go;
	logic               free_go;
	logic               found;
	logic [OFF_W-1:0]   pos;
	logic [BLK_W-1:0]   cand;
	logic               cand_ok;
	logic [WADDR_W:0]   word_nxt;
	logic               scan_last;
	logic [BLK_W:0]     cand_inc;

	// effective limits
	always_comb begin
		tot     = (total > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total;
		res_eff = (reserved < tot) ? reserved : tot;
	end

	assign alloc_go = (free_q != '0) && ({1'b0, hint_q} < tot);
	assign free_go  = ({1'b0, req_block} < CNT_W'(MAX_BLOCKS));

	// word search for allocate
	bba_scan u_scan (
		.word  (map_data),
		.first (first_q),
		.off   (off_q),
		.found (found),
		.pos   (pos)
	);

	// candidate block and end of search
	always_comb begin
		cand      = {word_q, pos};
		cand_ok   = ({1'b0, cand} < tot) && ({1'b0, cand} >= reserved);
		word_nxt  = {1'b0, word_q} + (WADDR_W + 1)'(1);
		scan_last = CNT_W'({word_nxt, {OFF_W{1'b0}}}) >= tot;
		cand_inc  = {1'b0, cand} + (BLK_W + 1)'(1);
	end

	// bitmap memory requests
	always_comb begin
		map_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_kind == KIND_ALLOC && alloc_go) begin
						map_req.rd_en = 1'b1;
						map_req.addr  = hint_q[BLK_W-1:OFF_W];
					end else if (req_kind == KIND_FREE && free_go) begin
						map_req.rd_en = 1'b1;
						map_req.addr  = req_block[BLK_W-1:OFF_W];
					end else if (req_kind == KIND_INIT) begin
						map_req.clr = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (found) begin
					if (cand_ok) begin
						map_req.wr_en = 1'b1;
						map_req.addr  = word_q;
						map_req.wdata = map_data | (WORD_W'(1) << pos);
					end
				end else if (!scan_last) begin
					map_req.rd_en = 1'b1;
					map_req.addr  = word_nxt[WADDR_W-1:0];
				end
			end
			S_FREE_WB: begin
				map_req.wr_en = 1'b1;
				map_req.addr  = bn_q[BLK_W-1:OFF_W];
				map_req.wdata = map_data & ~(WORD_W'(1) << bn_q[OFF_W-1:0]);
			end
			S_FILL: begin
				map_req.addr = word_q;
				if (fill_q >= CNT_W'(WORD_W)) begin
					map_req.wr_en = 1'b1;
					map_req.wdata = ALL_ONES;
				end else if (fill_q != '0) begin
					map_req.wr_en = 1'b1;
					map_req.wdata = ~(ALL_ONES << fill_q[OFF_W-1:0]);
				end
			end
			S_RESP: begin
				map_req = '0;
			end
			default: begin
				map_req = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			free_q   <= '0;
			hint_q   <= '0;
			word_q   <= '0;
			first_q  <= 1'b0;
			off_q    <= '0;
			fill_q   <= '0;
			bn_q     <= '0;
			status_q <= 1'b0;
			block_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						status_q <= 1'b0;
						block_q  <= '0;
						unique case (req_kind)
							KIND_INIT: begin
								free_q  <= tot - res_eff;
								hint_q  <= (res_eff < tot) ? res_eff[BLK_W-1:0] : '0;
								fill_q  <= res_eff;
								word_q  <= '0;
								state_q <= S_FILL;
							end
							KIND_ALLOC: begin
								if (alloc_go) begin
									word_q  <= hint_q[BLK_W-1:OFF_W];
									off_q   <= hint_q[OFF_W-1:0];
									first_q <= 1'b1;
									state_q <= S_SCAN;
								end else begin
									status_q <= 1'b1;
									state_q  <= S_RESP;
								end
							end
							KIND_FREE: begin
								bn_q <= req_block;
								if (free_go) begin
									state_q <= S_FREE_WB;
								end else begin
									status_q <= 1'b1;
									state_q  <= S_RESP;
								end
							end
							default: begin
								status_q <= 1'b1;
								state_q  <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					first_q <= 1'b0;
					if (found) begin
						if (cand_ok) begin
							block_q <= cand;
							free_q  <= free_q - CNT_W'(1);
							hint_q  <= (cand_inc < tot) ? cand_inc[BLK_W-1:0] : '0;
						end else begin
							status_q <= 1'b1;
						end
						state_q <= S_RESP;
					end else if (scan_last) begin
						status_q <= 1'b1;
						state_q  <= S_RESP;
					end else begin
						word_q <= word_nxt[WADDR_W-1:0];
					end
				end
				S_FREE_WB: begin
					if (bn_q < hint_q) begin
						hint_q <= bn_q;
					end
					if (free_q < tot) begin
						free_q <= free_q + CNT_W'(1);
					end
					state_q <= S_RESP;
				end
				S_FILL: begin
					if (fill_q >= CNT_W'(WORD_W)) begin
						fill_q <= fill_q - CNT_W'(WORD_W);
						word_q <= word_q + WADDR_W'(1);
					end else begin
						fill_q  <= '0;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready  = (state_q == S_IDLE);
	assign rsp_valid  = (state_q == S_RESP);
	assign rsp.status = status_q;
	assign rsp.block  = block_q;
	assign rsp.count  = free_q;

endmodule

FILE: sv/bitmap_block_allocator.sv
`timescale 1ns / 1ps

// channel   handshake                 payload
// input     in_valid / in_ready       kind, block_number
// output    out_valid / out_ready     status, allocated_block, free_count
// config    cfg_we                    cfg_index, cfg_data
//
// allocate: reads bitmap words from the hint until one has a clear bit, up to
//   MAX_BLOCKS/32 words; the single-port bitmap memory reads one word a cycle
// free: read, write back, result; no space or unknown kind: result only
// init: clear valid bits, then one fill write per reserved word (reserved capped at total)
// reset clears the per-word valid bits at once, so no clearing pass is needed
// a result waits in the output register; the next request is taken meanwhile,
//   and the sequencer holds its next result until the register is free

module bitmap_block_allocator
	import bba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	input  logic [BLK_W-1:0]  block_number,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              status,
	output logic [BLK_W-1:0]  allocated_block,
	output logic [CNT_W-1:0]  free_count
);

	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  reserved_q;
	logic              out_vld_q;
	rsp_t              out_q;
	logic              rsp_valid;
	logic              rsp_take;
	rsp_t              rsp;
	map_req_t          map_req;
	logic [WORD_W-1:0] map_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RST;
			reserved_q <= RESERVED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL:    total_q    <= cfg_data;
				CFG_RESERVED: reserved_q <= cfg_data;
				default:      total_q    <= total_q;
			endcase
		end
	end

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.total     (total_q),
		.reserved  (reserved_q),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req_kind  (kind),
		.req_block (block_number),
		.rsp_valid (rsp_valid),
		.rsp_take  (rsp_take),
		.rsp       (rsp),
		.map_req   (map_req),
		.map_data  (map_data)
	);

	bba_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (map_req),
		.rd_data (map_data)
	);

	// output register
	assign rsp_take = rsp_valid && (!out_vld_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rsp_take) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			out_q <= rsp;
		end
	end

	assign out_valid       = out_vld_q;
	assign status          = out_q.status;
	assign allocated_block = out_q.block;
	assign free_count      = out_q.count;

endmodule
